// ===== rtl/sba_pkg.sv =====
// Package for the slab bump allocator: sizes, codes, state encoding and
// small helper functions. Used by slab_bump_allocator_top; no dependencies.
package sba_pkg;

  // Table size and arithmetic widths
  localparam int MAX_SLABS          = 8;
  localparam int SLAB_GRANULE_BYTES = 2097152;
  localparam int SIZE_BITS          = 40;

  localparam int IDX_W   = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
  localparam int CNT_W   = $clog2(MAX_SLABS + 1);
  localparam int CAP_W   = SIZE_BITS + 1;        // capacity and offset entries
  localparam int BEGIN_W = CAP_W + 1;            // offset rounded up to alignment
  localparam int END_W   = CAP_W + 2;            // aligned offset plus size
  localparam int SUM_W   = 44;                   // reported sums
  localparam int USED_W  = CAP_W + IDX_W + 1;    // unsaturated offset sum
  localparam int MASK_W  = 32;                   // alignment mask, up to 2^31 - 1

  // Field widths
  localparam int CMD_W     = 2;
  localparam int REQ_W     = 39;
  localparam int LG_W      = 5;
  localparam int STATUS_W  = 2;
  localparam int OUT_IDX_W = 3;
  localparam int OFF_W     = 40;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 136;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = SIZE_BITS;

  localparam int MIN_ALIGN_LG = 6;
  localparam logic [SIZE_BITS-1:0] RESET_MIN_SLAB = SIZE_BITS'(134217728);
  localparam logic [CAP_W-1:0]     GRAN_MASK = CAP_W'(SLAB_GRANULE_BYTES - 1);
  localparam logic [SUM_W-1:0]     SUM_MAX   = {SUM_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC    = 2'd0,
    CMD_CLR_OFFS = 2'd1,
    CMD_CLR_HW   = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_ZERO     = 2'd1,
    ST_DISABLED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_POOL_EN  = 1'd0,
    CFG_MIN_SLAB = 1'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_USED,
    S_ADD1,
    S_ADD2,
    S_ADD3,
    S_MARK,
    S_OUT
  } state_t;

  // Alignment mask: 2^lg - 1, with the alignment raised to at least 64
  function automatic logic [MASK_W-1:0] align_mask(input logic [LG_W-1:0] lg);
    logic [LG_W-1:0] e;
    e = (lg < LG_W'(MIN_ALIGN_LG)) ? LG_W'(MIN_ALIGN_LG) : lg;
    return (MASK_W'(1) << e) - MASK_W'(1);
  endfunction

  // Saturate the unsaturated offset sum to the reported width
  function automatic logic [SUM_W-1:0] sat_used(input logic [USED_W-1:0] v);
    return (v > USED_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(v);
  endfunction

endpackage

// ===== rtl/sba_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/slab_bump_allocator_top.sv =====
// Slab bump allocator: top level with control sequencer and slab tables.
// Depends on sba_pkg and sba_ram.
//
// One command is taken at a time and gives exactly one result transfer.
// Capacities and bump offsets of the slabs sit in two small RAMs with a
// registered read; an allocation reads the slabs in index order through a
// two-stage check (align, then fit) at one slab per cycle. An allocation
// that fits an existing slab goes through the scan, the offset-sum update,
// the mark update and the output state; one that adds a new slab goes
// through the add states after the scan, or straight to them when the
// table is empty, then the mark update and the output state; a request
// refused for a full table scans every slab before the output state; the
// clear commands, the unused command and requests refused for a zero size
// or a disabled pool go straight to the output state. The offset sum and the
// capacity total are kept as running registers, so the high-water mark costs
// only the mark update state rather than a pass over the table. A new command
// is taken while the previous result still waits in the output register.
module slab_bump_allocator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // input: cmd[1:0], request_bytes[40:2], align_log2[45:41], zero pad above
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sba_pkg::IN_DATA_W-1:0]   in_tdata,
  // result: status[1:0], slab_index[4:2], byte_offset[44:5], slab_added[45],
  // total_capacity[89:46], watermark[133:90], zero pad above
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sba_pkg::OUT_DATA_W-1:0]  out_tdata,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [sba_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [sba_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // Configuration registers
  logic                            pool_en_r;
  logic [sba_pkg::SIZE_BITS-1:0]   min_slab_r;

  // Sequencer and request
  sba_pkg::state_t                 state_r, state_nxt;
  sba_pkg::cmd_t                   cmd_r, cmd_nxt;
  logic [sba_pkg::REQ_W-1:0]       bytes_r, bytes_nxt;
  logic [sba_pkg::MASK_W-1:0]      mask_r, mask_nxt;

  // Allocator state outside the RAMs
  logic [sba_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [sba_pkg::MAX_SLABS-1:0]   off_valid_r, off_valid_nxt;
  logic [sba_pkg::USED_W-1:0]      used_r, used_nxt;
  logic [sba_pkg::SUM_W-1:0]       total_r, total_nxt;
  logic [sba_pkg::SUM_W-1:0]       hw_r, hw_nxt;

  // Scan pipeline
  logic [sba_pkg::CNT_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic                            s1_v_r, s1_v_nxt;
  logic [sba_pkg::IDX_W-1:0]       s1_idx_r, s1_idx_nxt;
  logic                            s2_v_r, s2_v_nxt;
  logic [sba_pkg::IDX_W-1:0]       s2_idx_r, s2_idx_nxt;
  logic [sba_pkg::BEGIN_W-1:0]     s2_begin_r, s2_begin_nxt;
  logic [sba_pkg::CAP_W-1:0]       s2_off_r, s2_off_nxt;
  logic [sba_pkg::CAP_W-1:0]       s2_cap_r, s2_cap_nxt;

  // Update operands and new-slab sizing
  logic [sba_pkg::CAP_W-1:0]       old_off_r, old_off_nxt;
  logic [sba_pkg::CAP_W-1:0]       new_off_r, new_off_nxt;
  logic [sba_pkg::CAP_W-1:0]       want_r, want_nxt;
  logic [sba_pkg::CAP_W-1:0]       cap_r, cap_nxt;

  // Result held until the output register is free
  sba_pkg::status_t                res_status_r, res_status_nxt;
  logic [sba_pkg::IDX_W-1:0]       res_idx_r, res_idx_nxt;
  logic [sba_pkg::OFF_W-1:0]       res_off_r, res_off_nxt;
  logic                            res_added_r, res_added_nxt;

  // Output register
  logic                            out_valid_r, out_valid_nxt;
  logic [sba_pkg::OUT_DATA_W-1:0]  out_data_r, out_data_nxt;

  // RAM ports
  logic                            cap_we, off_we;
  logic [sba_pkg::IDX_W-1:0]       ram_raddr, off_waddr;
  logic [sba_pkg::CAP_W-1:0]       off_wdata;
  logic [sba_pkg::CAP_W-1:0]       cap_rdata, off_rdata;

  // Datapath helpers
  logic                            in_xfer;
  logic [sba_pkg::CAP_W-1:0]       s1_off;
  logic [sba_pkg::BEGIN_W-1:0]     s1_begin;
  logic [sba_pkg::END_W-1:0]       s2_end;
  logic                            s2_fit;
  logic                            s2_last;
  logic [sba_pkg::CAP_W-1:0]       sel_size;
  logic [sba_pkg::SUM_W:0]         total_sum;
  logic [sba_pkg::SUM_W-1:0]       used_sat;

  assign in_tready  = (state_r == sba_pkg::S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Slab tables
  sba_ram #(.WIDTH(sba_pkg::CAP_W), .DEPTH(sba_pkg::MAX_SLABS)) u_cap_ram (
    .clk   (clk),
    .we    (cap_we),
    .waddr (count_r[sba_pkg::IDX_W-1:0]),
    .wdata (cap_r),
    .raddr (ram_raddr),
    .rdata (cap_rdata)
  );

  sba_ram #(.WIDTH(sba_pkg::CAP_W), .DEPTH(sba_pkg::MAX_SLABS)) u_off_ram (
    .clk   (clk),
    .we    (off_we),
    .waddr (off_waddr),
    .wdata (off_wdata),
    .raddr (ram_raddr),
    .rdata (off_rdata)
  );

  assign ram_raddr = rd_idx_r[sba_pkg::IDX_W-1:0];

  // Stage 1: round the stored offset up to the alignment
  assign s1_off   = off_valid_r[s1_idx_r] ? off_rdata : '0;
  assign s1_begin = (sba_pkg::BEGIN_W'(s1_off) + sba_pkg::BEGIN_W'(mask_r))
                    & ~sba_pkg::BEGIN_W'(mask_r);

  // Stage 2: check that the request fits behind the aligned offset
  assign s2_end  = sba_pkg::END_W'(s2_begin_r) + sba_pkg::END_W'(bytes_r);
  assign s2_fit  = (s2_end <= sba_pkg::END_W'(s2_cap_r));
  assign s2_last = ((sba_pkg::CNT_W'(s2_idx_r) + sba_pkg::CNT_W'(1)) == count_r);

  // New slab: larger of the minimum and the granule-rounded need
  assign sel_size  = (sba_pkg::CAP_W'(min_slab_r) > want_r) ?
                     sba_pkg::CAP_W'(min_slab_r) : want_r;
  assign total_sum = {1'b0, total_r} + (sba_pkg::SUM_W + 1)'(cap_r);
  assign used_sat  = sba_pkg::sat_used(used_r);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_en_r  <= 1'b1;
      min_slab_r <= sba_pkg::RESET_MIN_SLAB;
    end else if (cfg_we) begin
      case (sba_pkg::cfg_idx_t'(cfg_addr))
        sba_pkg::CFG_POOL_EN:  pool_en_r  <= cfg_wdata[0];
        sba_pkg::CFG_MIN_SLAB: min_slab_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sba_pkg::S_IDLE;
      count_r     <= '0;
      off_valid_r <= '0;
      used_r      <= '0;
      total_r     <= '0;
      hw_r        <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      off_valid_r <= off_valid_nxt;
      used_r      <= used_nxt;
      total_r     <= total_nxt;
      hw_r        <= hw_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    bytes_r      <= bytes_nxt;
    mask_r       <= mask_nxt;
    rd_idx_r     <= rd_idx_nxt;
    s1_idx_r     <= s1_idx_nxt;
    s2_idx_r     <= s2_idx_nxt;
    s2_begin_r   <= s2_begin_nxt;
    s2_off_r     <= s2_off_nxt;
    s2_cap_r     <= s2_cap_nxt;
    old_off_r    <= old_off_nxt;
    new_off_r    <= new_off_nxt;
    want_r       <= want_nxt;
    cap_r        <= cap_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_off_r    <= res_off_nxt;
    res_added_r  <= res_added_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Sequencer: next state, table updates and result
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    bytes_nxt      = bytes_r;
    mask_nxt       = mask_r;
    count_nxt      = count_r;
    off_valid_nxt  = off_valid_r;
    used_nxt       = used_r;
    total_nxt      = total_r;
    hw_nxt         = hw_r;
    rd_idx_nxt     = rd_idx_r;
    s1_v_nxt       = 1'b0;
    s1_idx_nxt     = s1_idx_r;
    s2_v_nxt       = 1'b0;
    s2_idx_nxt     = s2_idx_r;
    s2_begin_nxt   = s2_begin_r;
    s2_off_nxt     = s2_off_r;
    s2_cap_nxt     = s2_cap_r;
    old_off_nxt    = old_off_r;
    new_off_nxt    = new_off_r;
    want_nxt       = want_r;
    cap_nxt        = cap_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_off_nxt    = res_off_r;
    res_added_nxt  = res_added_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    cap_we         = 1'b0;
    off_we         = 1'b0;
    off_waddr      = s2_idx_r;
    off_wdata      = s2_end[sba_pkg::CAP_W-1:0];

    case (state_r)
      // Take a command and sort out the cases that touch no slab
      sba_pkg::S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt        = sba_pkg::cmd_t'(in_tdata[1:0]);
          bytes_nxt      = in_tdata[40:2];
          mask_nxt       = sba_pkg::align_mask(in_tdata[45:41]);
          rd_idx_nxt     = '0;
          res_status_nxt = sba_pkg::ST_OK;
          res_idx_nxt    = '0;
          res_off_nxt    = '0;
          res_added_nxt  = 1'b0;
          state_nxt      = sba_pkg::S_OUT;
          case (sba_pkg::cmd_t'(in_tdata[1:0]))
            sba_pkg::CMD_ALLOC: begin
              if (!pool_en_r) begin
                res_status_nxt = sba_pkg::ST_DISABLED;
              end else if (in_tdata[40:2] == '0) begin
                res_status_nxt = sba_pkg::ST_ZERO;
              end else if (count_r == '0) begin
                state_nxt = sba_pkg::S_ADD1;
              end else begin
                state_nxt = sba_pkg::S_SCAN;
              end
            end
            sba_pkg::CMD_CLR_OFFS: begin
              off_valid_nxt = '0;
              used_nxt      = '0;
            end
            sba_pkg::CMD_CLR_HW: begin
              hw_nxt = '0;
            end
            default: ;
          endcase
        end
      end

      // Read one slab a cycle; align in stage 1, fit check in stage 2
      sba_pkg::S_SCAN: begin
        if (rd_idx_r < count_r) begin
          s1_v_nxt   = 1'b1;
          s1_idx_nxt = rd_idx_r[sba_pkg::IDX_W-1:0];
          rd_idx_nxt = rd_idx_r + sba_pkg::CNT_W'(1);
        end
        if (s1_v_r) begin
          s2_v_nxt     = 1'b1;
          s2_idx_nxt   = s1_idx_r;
          s2_begin_nxt = s1_begin;
          s2_off_nxt   = s1_off;
          s2_cap_nxt   = cap_rdata;
        end
        if (s2_v_r) begin
          if (s2_fit) begin
            // Bump the offset of the first slab that fits
            off_we                  = 1'b1;
            off_valid_nxt[s2_idx_r] = 1'b1;
            old_off_nxt             = s2_off_r;
            new_off_nxt             = s2_end[sba_pkg::CAP_W-1:0];
            res_idx_nxt             = s2_idx_r;
            res_off_nxt             = sba_pkg::OFF_W'(s2_begin_r);
            s1_v_nxt                = 1'b0;
            s2_v_nxt                = 1'b0;
            state_nxt               = sba_pkg::S_USED;
          end else if (s2_last) begin
            s1_v_nxt = 1'b0;
            s2_v_nxt = 1'b0;
            if (count_r == sba_pkg::CNT_W'(sba_pkg::MAX_SLABS)) begin
              res_status_nxt = sba_pkg::ST_FULL;
              state_nxt      = sba_pkg::S_OUT;
            end else begin
              state_nxt = sba_pkg::S_ADD1;
            end
          end
        end
      end

      // Replace the old offset in the running sum
      sba_pkg::S_USED: begin
        used_nxt  = used_r - sba_pkg::USED_W'(old_off_r) + sba_pkg::USED_W'(new_off_r);
        state_nxt = sba_pkg::S_MARK;
      end

      // Size plus alignment, rounded up to the granule
      sba_pkg::S_ADD1: begin
        want_nxt  = (sba_pkg::CAP_W'(bytes_r) + sba_pkg::CAP_W'(mask_r)
                     + sba_pkg::CAP_W'(1) + sba_pkg::GRAN_MASK) & ~sba_pkg::GRAN_MASK;
        state_nxt = sba_pkg::S_ADD2;
      end

      // Raise to the minimum slab size and round again
      sba_pkg::S_ADD2: begin
        cap_nxt   = (sel_size + sba_pkg::GRAN_MASK) & ~sba_pkg::GRAN_MASK;
        state_nxt = sba_pkg::S_ADD3;
      end

      // Append the new slab with the allocation at offset zero
      sba_pkg::S_ADD3: begin
        cap_we                                       = 1'b1;
        off_we                                       = 1'b1;
        off_waddr                                    = count_r[sba_pkg::IDX_W-1:0];
        off_wdata                                    = sba_pkg::CAP_W'(bytes_r);
        off_valid_nxt[count_r[sba_pkg::IDX_W-1:0]]   = 1'b1;
        count_nxt                                    = count_r + sba_pkg::CNT_W'(1);
        total_nxt      = total_sum[sba_pkg::SUM_W] ? sba_pkg::SUM_MAX
                                                   : total_sum[sba_pkg::SUM_W-1:0];
        used_nxt       = used_r + sba_pkg::USED_W'(bytes_r);
        res_idx_nxt    = count_r[sba_pkg::IDX_W-1:0];
        res_off_nxt    = '0;
        res_added_nxt  = 1'b1;
        state_nxt      = sba_pkg::S_MARK;
      end

      // Keep the greater of the mark and the saturated offset sum
      sba_pkg::S_MARK: begin
        if (used_sat > hw_r) begin
          hw_nxt = used_sat;
        end
        state_nxt = sba_pkg::S_OUT;
      end

      // Load the output register once it is free
      sba_pkg::S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, hw_r, total_r, res_added_r, res_off_r,
                           sba_pkg::OUT_IDX_W'(res_idx_r), res_status_r};
          state_nxt     = sba_pkg::S_IDLE;
        end
      end

      default: state_nxt = sba_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  // The slab count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sba_pkg::CNT_W'(sba_pkg::MAX_SLABS))
    else $error("slab count beyond table size");

  // Adding a slab advances the count by exactly one
  a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sba_pkg::S_ADD3) |=> (count_r == $past(count_r) + sba_pkg::CNT_W'(1)))
    else $error("slab add did not advance the count");

  // After the mark update the mark covers the current offset sum
  a_hw_covers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sba_pkg::S_MARK) |=> (hw_r >= used_sat))
    else $error("high-water mark below offset sum");

  // A fitting slab ends the scan and its offset moves forward
  a_hit_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sba_pkg::S_SCAN && s2_v_r && s2_fit) |=>
      (state_r == sba_pkg::S_USED && new_off_r >= old_off_r))
    else $error("scan hit without offset advance");
`endif

endmodule

// ===== test/tb_slab_bump_allocator_top.sv =====
// Testbench for slab_bump_allocator_top: directed and random allocation traffic,
// checked result by result against a predictor of the slab table kept in this file.
// Depends on sba_pkg and the RTL of slab_bump_allocator_top.
module tb_slab_bump_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sba_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam logic [REQ_W-1:0] REQ_MAX = {REQ_W{1'b1}};

  typedef struct packed {
    status_t              status;
    logic [OUT_IDX_W-1:0] slab;
    logic [OFF_W-1:0]     offset;
    logic                 added;
    logic [SUM_W-1:0]     total_cap;
    logic [SUM_W-1:0]     watermark;
  } alloc_result_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = CFG_POOL_EN;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  // Predicted slab table and configuration
  logic [63:0] cap_tab [MAX_SLABS];
  logic [63:0] off_tab [MAX_SLABS];
  int          n_slabs;
  logic [63:0] hw_mark;
  logic        pool_on;
  logic [63:0] min_slab;

  alloc_result_t owed_results[$];
  int            mismatches   = 0;
  int            quiet_cycles = 0;
  int unsigned   in_idle_pct  = 0;
  int unsigned   out_idle_pct = 0;

  slab_bump_allocator_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result channel at the current rate
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  function automatic logic [63:0] ceil_to(input logic [63:0] v, input logic [63:0] a);
    return (v + a - 64'd1) / a * a;
  endfunction

  // Sum of capacities or offsets over the live slabs, saturated to the report width
  function automatic logic [63:0] slab_sum(input bit of_caps);
    logic [63:0] s;
    s = '0;
    for (int i = 0; i < n_slabs; i++) begin
      s += of_caps ? cap_tab[i] : off_tab[i];
    end
    return (s > 64'(SUM_MAX)) ? 64'(SUM_MAX) : s;
  endfunction

  // Apply one command to the predicted table and return the result it gives
  function automatic alloc_result_t next_alloc_result(input cmd_t c,
                                                      input logic [REQ_W-1:0] bytes,
                                                      input logic [LG_W-1:0] lg);
    alloc_result_t r;
    logic [63:0]   align;
    logic [63:0]   start_off;
    logic [63:0]   want;
    logic [63:0]   used;
    bit            placed;
    r        = '0;
    r.status = ST_OK;
    placed   = 1'b0;
    case (c)
      CMD_ALLOC: begin
        align = 64'd1 << lg;
        if (align < 64'd64) align = 64'd64;
        if (!pool_on) begin
          r.status = ST_DISABLED;
        end else if (bytes == '0) begin
          r.status = ST_ZERO;
        end else begin
          // first fit in index order
          for (int i = 0; i < n_slabs; i++) begin
            if (!placed) begin
              start_off = ceil_to(off_tab[i], align);
              if (start_off <= cap_tab[i] && 64'(bytes) <= cap_tab[i] - start_off) begin
                off_tab[i] = start_off + 64'(bytes);
                r.slab     = OUT_IDX_W'(i);
                r.offset   = OFF_W'(start_off);
                placed     = 1'b1;
              end
            end
          end
          // no fit: open a new slab or refuse
          if (!placed) begin
            if (n_slabs >= MAX_SLABS) begin
              r.status = ST_FULL;
            end else begin
              want = ceil_to(64'(bytes) + align, 64'(SLAB_GRANULE_BYTES));
              if (min_slab > want) want = min_slab;
              cap_tab[n_slabs] = ceil_to(want, 64'(SLAB_GRANULE_BYTES));
              off_tab[n_slabs] = 64'(bytes);
              r.slab  = OUT_IDX_W'(n_slabs);
              r.added = 1'b1;
              n_slabs++;
              placed  = 1'b1;
            end
          end
          if (placed) begin
            used = slab_sum(1'b0);
            if (used > hw_mark) hw_mark = used;
          end
        end
      end
      CMD_CLR_OFFS: begin
        for (int i = 0; i < MAX_SLABS; i++) off_tab[i] = '0;
      end
      CMD_CLR_HW: hw_mark = '0;
      default: ;
    endcase
    r.total_cap = SUM_W'(slab_sum(1'b1));
    r.watermark = SUM_W'(hw_mark);
    return r;
  endfunction

  // Offer one command, hold it until the transfer, then log the expected result
  task automatic send_cmd(input cmd_t c, input logic [REQ_W-1:0] bytes,
                          input logic [LG_W-1:0] lg);
    bit rdy;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= IN_DATA_W'({lg, bytes, c});
    in_tvalid <= 1'b1;
    rdy = 1'b0;
    while (!rdy) begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end
    owed_results.push_back(next_alloc_result(c, bytes, lg));
  endtask

  // Drop valid and hold until every owed result has arrived
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (owed_results.size() != 0);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_POOL_EN:  pool_on  = val[0];
      CFG_MIN_SLAB: min_slab = 64'(val);
      default: ;
    endcase
  endtask

  task automatic test_basic_commands();
    send_cmd(CMD_ALLOC, REQ_W'(1), LG_W'(0));
    send_cmd(CMD_ALLOC, REQ_W'(100), LG_W'(7));
    send_cmd(CMD_ALLOC, '0, LG_W'(5));
    send_cmd(CMD_NOP, 39'h55_5555_5555, LG_W'(31));
    send_cmd(CMD_CLR_HW, '0, '0);
    send_cmd(CMD_CLR_OFFS, REQ_MAX, LG_W'(21));
    // huge alignment: first fits at offset 0, second forces a new slab
    send_cmd(CMD_ALLOC, REQ_W'(1), LG_W'(31));
    send_cmd(CMD_ALLOC, REQ_W'(1), LG_W'(31));
  endtask

  task automatic test_min_slab_extremes();
    cfg_write(CFG_MIN_SLAB, '0);
    send_cmd(CMD_ALLOC, 39'h1_0000_0000, LG_W'(0));
    cfg_write(CFG_MIN_SLAB, 40'h80_0000_0000);
    send_cmd(CMD_CLR_OFFS, '0, '0);
    send_cmd(CMD_ALLOC, 39'h2_0000_0000, LG_W'(0));
    cfg_write(CFG_MIN_SLAB, CFG_DATA_W'(SLAB_GRANULE_BYTES));
    send_cmd(CMD_ALLOC, REQ_MAX, LG_W'(21));
  endtask

  task automatic test_pool_disable();
    cfg_write(CFG_POOL_EN, '0);
    send_cmd(CMD_ALLOC, REQ_W'(5), LG_W'(3));
    send_cmd(CMD_ALLOC, '0, '0);
    send_cmd(CMD_CLR_OFFS, '0, '0);
    send_cmd(CMD_CLR_HW, '0, '0);
    cfg_write(CFG_POOL_EN, CFG_DATA_W'(1));
    send_cmd(CMD_ALLOC, REQ_W'(64), LG_W'(6));
  endtask

  // Push maximum-size requests until the table refuses one
  task automatic test_table_full();
    bit full_seen;
    full_seen = 1'b0;
    for (int k = 0; k < 20 && !full_seen; k++) begin
      send_cmd(CMD_ALLOC, REQ_MAX, '0);
      full_seen = (owed_results[$].status == ST_FULL);
    end
  endtask

  task automatic test_random_traffic(input int n_items, input int unsigned in_pct,
                                     input int unsigned out_pct);
    int unsigned      r;
    cmd_t             c;
    logic [REQ_W-1:0] b;
    logic [LG_W-1:0]  lg;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 80)      c = CMD_ALLOC;
      else if (r < 88) c = CMD_CLR_OFFS;
      else if (r < 95) c = CMD_CLR_HW;
      else             c = CMD_NOP;
      // mostly small sizes, a tail of large and full-width ones
      r = $urandom_range(0, 99);
      if (r < 5)       b = '0;
      else if (r < 55) b = REQ_W'($urandom_range(1, 4096));
      else if (r < 80) b = REQ_W'($urandom_range(1, 4194304));
      else if (r < 93) b = REQ_W'($urandom);
      else             b = REQ_W'({$urandom, $urandom});
      lg = ($urandom_range(0, 99) < 70) ? LG_W'($urandom_range(0, 12))
                                        : LG_W'($urandom_range(0, 31));
      send_cmd(c, b, lg);
      if ($urandom_range(0, 49) == 0) drain();
    end
  endtask

  task automatic report_bad(input string what, input alloc_result_t want,
                            input alloc_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: exp st=%0d idx=%0d off=%0d add=%0d cap=%0d hw=%0d", $realtime, what,
               want.status, want.slab, want.offset, want.added, want.total_cap,
               want.watermark);
      $display("%0t %s: got st=%0d idx=%0d off=%0d add=%0d cap=%0d hw=%0d", $realtime, what,
               got.status, got.slab, got.offset, got.added, got.total_cap, got.watermark);
    end
  endtask

  // Compare each result transfer with the oldest owed result
  always @(negedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status    = status_t'(out_tdata[1:0]);
      got.slab      = out_tdata[4:2];
      got.offset    = out_tdata[44:5];
      got.added     = out_tdata[45];
      got.total_cap = out_tdata[89:46];
      got.watermark = out_tdata[133:90];
      if (owed_results.size() == 0) begin
        report_bad("unexpected result", '0, got);
      end else begin
        want = owed_results.pop_front();
        if (got.status !== want.status || got.slab !== want.slab ||
            got.offset !== want.offset || got.added !== want.added ||
            got.total_cap !== want.total_cap || got.watermark !== want.watermark) begin
          report_bad("result mismatch", want, got);
        end
      end
    end
  end

  // Watchdog: end the run after too long with no transfer on either side
  always @(negedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_slab_bump_allocator_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] rnd_min;
    for (int i = 0; i < MAX_SLABS; i++) begin
      cap_tab[i] = '0;
      off_tab[i] = '0;
    end
    n_slabs      = 0;
    hw_mark      = '0;
    pool_on      = 1'b1;
    min_slab     = 64'(RESET_MIN_SLAB);
    in_idle_pct  = 33;
    out_idle_pct = 83;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_commands();
    test_min_slab_extremes();
    test_pool_disable();
    test_random_traffic(270, 33, 83);
    rnd_min = {$urandom, $urandom} % ((64'd1 << 39) + 64'd1);
    cfg_write(CFG_MIN_SLAB, CFG_DATA_W'(rnd_min));
    test_random_traffic(270, 83, 33);
    test_table_full();
    test_random_traffic(260, 0, 0);

    // let the last results land, then a short tail for stray transfers
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("tb_slab_bump_allocator_top: done, clean");
    end else begin
      $display("tb_slab_bump_allocator_top: done, errors");
    end
    $finish;
  end

endmodule
